>>> hw/rtl/rls_pkg.sv
// Package for the RLS ARX identifier: widths, reset constants, sequencer states.
// Used by the cell and top level; no dependencies.
`default_nettype none
package rls_pkg;
  localparam int unsigned N = 5;
  localparam int unsigned FB = 24;
  localparam int unsigned SB = 12;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FB;
  localparam logic signed [31:0] SMAX = 32'sh7fffffff;
  localparam logic signed [31:0] SMIN = -32'sh7fffffff - 32'sd1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_AUX0, ST_AUX2, ST_DEN, ST_DIV, ST_PUPD, ST_ERR, ST_THETA, ST_OUT
  } state_e;

  typedef struct packed {
    logic       clr;
    logic       en;
  } cell_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x, output logic f);
    f = 1'b0;
    if (x > 64'(SMAX)) begin
      f = 1'b1;
      return SMAX;
    end
    if (x < 64'(SMIN)) begin
      f = 1'b1;
      return SMIN;
    end
    return x[31:0];
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/rls_mac_cell.sv
// One multiply-accumulate cell of the array: 32x32 product into a 64-bit accumulator.
// Depends on rls_pkg.
`default_nettype none
module rls_mac_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire rls_pkg::cell_ctl_t  ctl_i,
  input  wire logic signed [31:0]  a_i,
  input  wire logic signed [31:0]  b_i,
  input  wire logic signed [63:0]  acc_i,
  output logic signed [63:0]       acc_o
);
  logic signed [63:0] prod_q, prod_d;
  logic               vld_q;
  logic signed [63:0] acc_q, acc_d;

  assign prod_d = 64'(a_i) * 64'(b_i);

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clr) acc_d = acc_i;
    else if (vld_q) acc_d = acc_q + prod_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      acc_q <= '0;
    end else begin
      vld_q <= ctl_i.en;
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) prod_q <= prod_d;

  assign acc_o = acc_q;
endmodule
`default_nettype wire

>>> hw/rtl/rls_div.sv
// Restoring signed divider, one quotient bit per cycle, truncation toward zero.
// No dependencies.
`default_nettype none
module rls_div (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic signed [63:0]  num_i,
  input  wire logic signed [63:0]  den_i,
  output logic                     done_o,
  output logic signed [63:0]       quo_o
);
  logic [63:0] rem_q, rem_d, q_q, q_d, dv_q, dv_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [64:0] trial;

  always_comb begin
    rem_d = rem_q; q_d = q_q; dv_d = dv_q; cnt_d = cnt_q;
    neg_d = neg_q; busy_d = busy_q; done_d = 1'b0;
    trial = '0;
    if (start_i) begin
      rem_d = '0;
      q_d = num_i[63] ? 64'(-num_i) : 64'(num_i);
      dv_d = den_i[63] ? 64'(-den_i) : 64'(den_i);
      neg_d = num_i[63] ^ den_i[63];
      cnt_d = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, q_q[63]} - {1'b0, dv_q};
      if (!trial[64]) begin
        rem_d = trial[63:0];
        q_d = {q_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], q_q[63]};
        q_d = {q_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; q_q <= q_d; dv_q <= dv_d; neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quo_o = neg_q ? 64'(-q_q) : 64'(q_q);
endmodule
`default_nettype wire

>>> hw/rtl/rls_arx_identifier.sv
// RLS ARX identifier: sequencer, five parallel MAC cells, divider and state.
// Depends on rls_pkg, rls_mac_cell and rls_div.
// Work per sample: four MAC phases (P*phi, phi*P, denominator, error), five divisions,
// the P update, the theta step and the output step. A zero denominator skips the divisions.
// A new sample is accepted only in idle, once the previous result has been presented;
// a stalled result holds the output phase.
// Reset: P to identity, theta and sample history to zero, output empty.
`default_nettype none
module rls_arx_identifier (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,  // u_sample[15:0], y_sample[31:16]
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [191:0]      m_axis_tdata,  // theta_a1..b2, prediction_error
  output logic              m_axis_tuser   // saturated
);
  localparam int unsigned N = rls_pkg::N;

  rls_pkg::state_e st_q, st_d;
  logic [3:0] ix_q, ix_d;  // column/row index inside a phase
  logic [2:0] wt_q, wt_d;

  logic signed [31:0] p_q [N*N];
  logic signed [31:0] th_q [N];
  logic signed [15:0] yh_q [2];
  logic signed [15:0] uh_q [2];
  logic signed [31:0] phi_q [N];
  logic signed [15:0] y_q;
  logic signed [31:0] aux0_q [N];
  logic signed [31:0] aux2_q [N];
  logic signed [31:0] k_q [N];
  logic signed [63:0] den_q;
  logic signed [31:0] e_q;
  logic               sat_q;
  logic [192:0]       out_q;

  rls_pkg::cell_ctl_t ctl;
  logic signed [31:0] ca [N];
  logic signed [31:0] cb [N];
  logic signed [63:0] cacc [N];
  logic signed [63:0] cin [N];

  logic div_start, div_done;
  logic signed [63:0] quo;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      rls_mac_cell u_cell (
        .clk_i, .rst_ni, .ctl_i(ctl), .a_i(ca[g]), .b_i(cb[g]),
        .acc_i(cin[g]), .acc_o(cacc[g])
      );
    end
  endgenerate

  rls_div u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .num_i(64'(aux0_q[ix_q[2:0]]) <<< rls_pkg::FB), .den_i(den_q),
    .done_o(div_done), .quo_o(quo)
  );

  function automatic logic signed [63:0] rnd(input logic signed [63:0] x, input int unsigned s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // next state
  always_comb begin
    st_d = st_q; ix_d = ix_q; wt_d = wt_q;
    case (st_q)
      rls_pkg::ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          st_d = rls_pkg::ST_AUX0; ix_d = '0; wt_d = '0;
        end
      end
      rls_pkg::ST_AUX0, rls_pkg::ST_AUX2, rls_pkg::ST_DEN, rls_pkg::ST_ERR: begin
        // feed five columns, then wait for the pipe to drain
        if (ix_q < 4'(N)) ix_d = ix_q + 4'd1;
        else if (wt_q < 3'd2) wt_d = wt_q + 3'd1;
        else begin
          ix_d = '0; wt_d = '0;
          case (st_q)
            rls_pkg::ST_AUX0: st_d = rls_pkg::ST_AUX2;
            rls_pkg::ST_AUX2: st_d = rls_pkg::ST_DEN;
            rls_pkg::ST_DEN:  st_d = rls_pkg::ST_DIV;
            default:          st_d = rls_pkg::ST_THETA;
          endcase
        end
      end
      rls_pkg::ST_DIV: begin
        if (den_q == '0) begin
          st_d = rls_pkg::ST_PUPD; ix_d = '0;
        end else if (div_done) begin
          if (ix_q == 4'(N - 1)) begin
            st_d = rls_pkg::ST_PUPD; ix_d = '0;
          end else ix_d = ix_q + 4'd1;
        end
      end
      rls_pkg::ST_PUPD: begin
        if (ix_q == 4'(N - 1)) begin
          st_d = rls_pkg::ST_ERR; ix_d = '0;
        end else ix_d = ix_q + 4'd1;
      end
      rls_pkg::ST_THETA: st_d = rls_pkg::ST_OUT;
      rls_pkg::ST_OUT: if (!m_axis_tvalid || m_axis_tready) st_d = rls_pkg::ST_IDLE;
      default: st_d = rls_pkg::ST_IDLE;
    endcase
  end

  // divider start: on entry to a division and after each finished one
  logic div_run_q;
  assign div_start = (st_q == rls_pkg::ST_DIV) && (den_q != '0) && !div_run_q;

  // cell operands: cell g computes row/column g over five fed terms; the dot products use cell 0 only
  always_comb begin
    ctl.clr = (ix_q == '0) && (wt_q == '0);
    ctl.en = (ix_q < 4'(N));
    for (int c = 0; c < N; c++) begin
      ca[c] = '0; cb[c] = '0; cin[c] = '0;
    end
    for (int c = 0; c < N; c++) begin
      case (st_q)
        rls_pkg::ST_AUX0: begin
          ca[c] = p_q[c*N + int'(ix_q[2:0])]; cb[c] = phi_q[ix_q[2:0]];
        end
        rls_pkg::ST_AUX2: begin
          ca[c] = p_q[int'(ix_q[2:0])*N + c]; cb[c] = phi_q[ix_q[2:0]];
        end
        rls_pkg::ST_DEN: begin
          ca[c] = (c == 0) ? aux0_q[ix_q[2:0]] : '0; cb[c] = phi_q[ix_q[2:0]];
        end
        rls_pkg::ST_ERR: begin
          ca[c] = (c == 0) ? th_q[ix_q[2:0]] : '0; cb[c] = phi_q[ix_q[2:0]];
        end
        default: ;
      endcase
      if (ix_q >= 4'(N)) begin
        ca[c] = '0; cb[c] = '0;
      end
    end
  end

  logic done_phase;
  assign done_phase = (ix_q == 4'(N)) && (wt_q == 3'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= rls_pkg::ST_IDLE; ix_q <= '0; wt_q <= '0; div_run_q <= 1'b0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < N*N; i++) p_q[i] <= (i % (N + 1) == 0) ? rls_pkg::ONE : '0;
      for (int i = 0; i < N; i++) th_q[i] <= '0;
      yh_q[0] <= '0; yh_q[1] <= '0; uh_q[0] <= '0; uh_q[1] <= '0;
    end else begin
      logic f;
      logic signed [63:0] t;
      st_q <= st_d; ix_q <= ix_d; wt_q <= wt_d;
      if (div_start) div_run_q <= 1'b1;
      else if (div_done) div_run_q <= 1'b0;
      // present the new result once the output register is free, drop it on transfer
      if (st_q == rls_pkg::ST_OUT && (!m_axis_tvalid || m_axis_tready)) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (st_q)
        rls_pkg::ST_PUPD: begin
          for (int j = 0; j < N; j++) begin
            t = 64'(p_q[int'(ix_q[2:0])*N + j])
                - rnd(64'(k_q[ix_q[2:0]]) * 64'(aux2_q[j]), rls_pkg::FB);
            p_q[int'(ix_q[2:0])*N + j] <= rls_pkg::sat32(t, f);
          end
        end
        rls_pkg::ST_THETA: begin
          for (int i = 0; i < N; i++) begin
            t = 64'(th_q[i]) + rnd(64'(k_q[i]) * 64'(e_q), rls_pkg::FB);
            th_q[i] <= rls_pkg::sat32(t, f);
          end
          uh_q[1] <= uh_q[0]; uh_q[0] <= phi_q[2][15:0];
          yh_q[1] <= yh_q[0]; yh_q[0] <= y_q;
        end
        default: ;
      endcase
    end
  end

  // payload and step scratch
  always_ff @(posedge clk_i) begin
    logic f;
    logic sf;
    logic signed [63:0] t;
    sf = 1'b0;
    case (st_q)
      rls_pkg::ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
        phi_q[0] <= 32'(yh_q[0]); phi_q[1] <= 32'(yh_q[1]);
        phi_q[2] <= 32'($signed(s_axis_tdata[15:0]));
        phi_q[3] <= 32'(uh_q[0]); phi_q[4] <= 32'(uh_q[1]);
        y_q <= s_axis_tdata[31:16];
        sat_q <= 1'b0;
      end
      rls_pkg::ST_AUX0: if (done_phase) for (int c = 0; c < N; c++) begin
        aux0_q[c] <= rls_pkg::sat32(rnd(cacc[c], rls_pkg::SB), f);
        sf |= f;
      end
      rls_pkg::ST_AUX2: if (done_phase) for (int c = 0; c < N; c++) begin
        aux2_q[c] <= rls_pkg::sat32(rnd(cacc[c], rls_pkg::SB), f);
        sf |= f;
      end
      rls_pkg::ST_DEN: if (done_phase) den_q <= 64'(rls_pkg::ONE) + rnd(cacc[0], rls_pkg::SB);
      rls_pkg::ST_DIV: begin
        if (den_q == '0) begin
          for (int i = 0; i < N; i++) k_q[i] <= '0;
          sf = 1'b1;
        end else if (div_done) begin
          k_q[ix_q[2:0]] <= rls_pkg::sat32(quo, f);
          sf = f;
        end
      end
      rls_pkg::ST_PUPD: for (int j = 0; j < N; j++) begin
        t = 64'(p_q[int'(ix_q[2:0])*N + j])
            - rnd(64'(k_q[ix_q[2:0]]) * 64'(aux2_q[j]), rls_pkg::FB);
        t = 64'(rls_pkg::sat32(t, f));
        sf |= f;
      end
      rls_pkg::ST_ERR: if (done_phase) begin
        e_q <= rls_pkg::sat32((64'(y_q) <<< (rls_pkg::FB - rls_pkg::SB))
                              - rnd(cacc[0], rls_pkg::SB), f);
        sf = f;
      end
      rls_pkg::ST_THETA: begin
        // flag only; the updated estimate is latched in the state block
        for (int i = 0; i < N; i++) begin
          t = 64'(th_q[i]) + rnd(64'(k_q[i]) * 64'(e_q), rls_pkg::FB);
          t = 64'(rls_pkg::sat32(t, f));
          sf |= f;
        end
      end
      // load the payload only when the previous result has left
      rls_pkg::ST_OUT: if (!m_axis_tvalid || m_axis_tready) begin
        for (int i = 0; i < N; i++) out_q[32*i +: 32] <= th_q[i];
        out_q[32*N +: 32] <= e_q;
        out_q[32*N+32] <= sat_q;
      end
      default: ;
    endcase
    if (st_q != rls_pkg::ST_IDLE && sf) sat_q <= 1'b1;
  end

  assign s_axis_tready = (st_q == rls_pkg::ST_IDLE);
  assign m_axis_tdata = out_q[191:0];
  assign m_axis_tuser = out_q[192];

  ap_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == rls_pkg::ST_OUT && st_d == rls_pkg::ST_IDLE) |=> m_axis_tvalid)
    else $error("result not presented");
  ap_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != rls_pkg::ST_IDLE) |-> !s_axis_tready)
    else $error("accept while busy");
  ap_div_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == rls_pkg::ST_DIV) |-> (ix_q < 4'(N)))
    else $error("divide index out of range");
endmodule
`default_nettype wire

>>> tb/sv/rls_arx_identifier_tb.sv
// Testbench for rls_arx_identifier: drives sample transfers, predicts each estimate update.
// Depends on rls_pkg and the rls_arx_identifier RTL; needs no files or arguments.
`default_nettype none
module rls_arx_identifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        saturated;
    logic [31:0] pred_err;
    logic [31:0] b2;
    logic [31:0] b1;
    logic [31:0] b0;
    logic [31:0] a2;
    logic [31:0] a1;
  } rls_update_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;
  logic         m_axis_tuser;

  rls_arx_identifier dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state: covariance row major, estimate, sample history.
  longint      cov_m[rls_pkg::N*rls_pkg::N];
  longint      theta_v[rls_pkg::N];
  logic signed [15:0] y_hist[2];
  logic signed [15:0] u_hist[2];
  bit          clamp_flag;

  rls_update_t expected_updates[$];
  int          error_count = 0;
  int          update_count = 0;
  int          sat_count = 0;
  bit          steady_run = 1'b0;  // suppress idling on both sides

  function automatic longint round_sh(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint x);
    if (x > longint'(rls_pkg::SMAX)) begin
      clamp_flag = 1'b1;
      return longint'(rls_pkg::SMAX);
    end
    if (x < longint'(rls_pkg::SMIN)) begin
      clamp_flag = 1'b1;
      return longint'(rls_pkg::SMIN);
    end
    return x;
  endfunction

  function automatic void reset_estimator();
    for (int i = 0; i < rls_pkg::N*rls_pkg::N; i++) cov_m[i] = 0;
    for (int i = 0; i < rls_pkg::N; i++) begin
      cov_m[i*rls_pkg::N+i] = longint'(1) <<< rls_pkg::FB;
      theta_v[i] = 0;
    end
    y_hist = '{default: '0};
    u_hist = '{default: '0};
  endfunction

  // Run one RLS step on the predictor and return the expected result.
  function automatic rls_update_t rls_step(logic signed [15:0] u, logic signed [15:0] y);
    longint phi[rls_pkg::N];
    longint pphi[rls_pkg::N];
    longint phip[rls_pkg::N];
    longint gain[rls_pkg::N];
    longint acc;
    longint den;
    longint err;
    rls_update_t r;
    clamp_flag = 1'b0;
    phi[0] = y_hist[0];
    phi[1] = y_hist[1];
    phi[2] = u;
    phi[3] = u_hist[0];
    phi[4] = u_hist[1];
    for (int i = 0; i < rls_pkg::N; i++) begin
      acc = 0;
      for (int j = 0; j < rls_pkg::N; j++) acc += cov_m[i*rls_pkg::N+j] * phi[j];
      pphi[i] = clamp32(round_sh(acc, rls_pkg::SB));
    end
    for (int j = 0; j < rls_pkg::N; j++) begin
      acc = 0;
      for (int i = 0; i < rls_pkg::N; i++) acc += phi[i] * cov_m[i*rls_pkg::N+j];
      phip[j] = clamp32(round_sh(acc, rls_pkg::SB));
    end
    acc = 0;
    for (int i = 0; i < rls_pkg::N; i++) acc += phi[i] * pphi[i];
    den = (longint'(1) <<< rls_pkg::FB) + round_sh(acc, rls_pkg::SB);
    for (int i = 0; i < rls_pkg::N; i++) begin
      if (den == 0) begin
        gain[i] = 0;
        clamp_flag = 1'b1;
      end else begin
        gain[i] = clamp32((pphi[i] <<< rls_pkg::FB) / den);
      end
    end
    for (int i = 0; i < rls_pkg::N; i++)
      for (int j = 0; j < rls_pkg::N; j++)
        cov_m[i*rls_pkg::N+j] = clamp32(cov_m[i*rls_pkg::N+j]
                                        - round_sh(gain[i] * phip[j], rls_pkg::FB));
    acc = 0;
    for (int i = 0; i < rls_pkg::N; i++) acc += phi[i] * theta_v[i];
    err = clamp32((longint'(y) <<< (rls_pkg::FB - rls_pkg::SB)) - round_sh(acc, rls_pkg::SB));
    for (int i = 0; i < rls_pkg::N; i++)
      theta_v[i] = clamp32(theta_v[i] + round_sh(gain[i] * err, rls_pkg::FB));
    u_hist[1] = u_hist[0];
    u_hist[0] = u;
    y_hist[1] = y_hist[0];
    y_hist[0] = y;
    r.a1 = theta_v[0][31:0];
    r.a2 = theta_v[1][31:0];
    r.b0 = theta_v[2][31:0];
    r.b1 = theta_v[3][31:0];
    r.b2 = theta_v[4][31:0];
    r.pred_err = err[31:0];
    r.saturated = clamp_flag;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH update %0d %s: got %h expected %h", update_count, what, got, want);
    error_count++;
  endtask

  // Send one sample transfer; predict the update when the transfer is accepted.
  task automatic send_sample(logic signed [15:0] u, logic signed [15:0] y);
    if (!steady_run && $urandom_range(99) < 29) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 29);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, u};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_updates.push_back(rls_step(u, y));
  endtask

  task automatic drain_updates();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_updates.size() != 0) @(posedge clk_i);
  endtask

  // Randomly stall the result side unless a steady stretch is running.
  always @(posedge clk_i) begin
    m_axis_tready <= steady_run || ($urandom_range(99) >= 29);
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    rls_update_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata};
      if (expected_updates.size() == 0) begin
        $display("UNEXPECTED result transfer %h", m_axis_tdata);
        error_count++;
      end else begin
        want = expected_updates.pop_front();
        if (got.a1 !== want.a1) report_mismatch("theta_a1", got.a1, want.a1);
        if (got.a2 !== want.a2) report_mismatch("theta_a2", got.a2, want.a2);
        if (got.b0 !== want.b0) report_mismatch("theta_b0", got.b0, want.b0);
        if (got.b1 !== want.b1) report_mismatch("theta_b1", got.b1, want.b1);
        if (got.b2 !== want.b2) report_mismatch("theta_b2", got.b2, want.b2);
        if (got.pred_err !== want.pred_err)
          report_mismatch("prediction_error", got.pred_err, want.pred_err);
        if (got.saturated !== want.saturated)
          report_mismatch("saturated", 32'(got.saturated), 32'(want.saturated));
        if (want.saturated) sat_count++;
      end
      update_count++;
    end
  end

  // Extremes of both samples, zero input, and sign flips that drive P far off.
  task automatic test_directed_extremes();
    logic signed [15:0] vals[6] = '{16'sh0000, 16'sh7fff, -16'sh8000, 16'sh0001,
                                    -16'sh0001, 16'sh5555};
    send_sample('0, '0);
    for (int i = 0; i < 6; i++) send_sample(vals[i], vals[5 - i]);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(-16'sh8000, -16'sh8000);
    send_sample(16'sh7fff, -16'sh8000);
    send_sample(-16'sh8000, 16'sh7fff);
    send_sample(16'shaaaa, 16'sh5555);
    for (int i = 0; i < 8; i++) send_sample(i[0] ? 16'sh7fff : -16'sh8000, 16'sh7fff);
    drain_updates();
  endtask

  // Samples from a stable ARX plant with noise: the estimate should converge.
  task automatic test_plant_tracking(int count);
    int a1, a2, b0, b1, b2;
    int yp1, yp2, up1, up2, u, y;
    a1 = int'($urandom_range(2400)) - 1200;
    a2 = int'($urandom_range(1600)) - 800;
    b0 = int'($urandom_range(8192)) - 4096;
    b1 = int'($urandom_range(4096)) - 2048;
    b2 = int'($urandom_range(2048)) - 1024;
    yp1 = 0; yp2 = 0; up1 = 0; up2 = 0;
    for (int k = 0; k < count; k++) begin
      u = int'($urandom_range(16383)) - 8192;
      y = (a1 * yp1 + a2 * yp2 + b0 * u + b1 * up1 + b2 * up2) / 4096
          + int'($urandom_range(32)) - 16;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      send_sample(u[15:0], y[15:0]);
      yp2 = yp1; yp1 = y; up2 = up1; up1 = u;
    end
  endtask

  // Unstructured samples over the full range.
  task automatic test_random_noise(int count);
    for (int k = 0; k < count; k++)
      send_sample(16'($urandom), 16'($urandom));
  endtask

  initial begin
    reset_estimator();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    for (int blk = 0; blk < 12; blk++) begin
      test_plant_tracking(120);
      test_random_noise(25);
    end
    steady_run = 1'b1;
    test_plant_tracking(120);
    steady_run = 1'b0;
    test_random_noise(40);
    drain_updates();
    repeat (600) @(posedge clk_i);
    $display("Covered %0d estimate updates from plant, noise and extreme samples;",
             update_count);
    $display("%0d of them flagged saturation.", sat_count);
    if (error_count == 0 && expected_updates.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("TIMEOUT waiting for transfers");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
